// ===== design/svf_pkg.sv =====
`timescale 1ns / 1ps
package svf_pkg;

	// Formats and sizes.
	localparam int CHANNELS    = 2;
	localparam int IDX_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SAMPLE_BITS = 24;
	localparam int FRAC_BITS   = 20;
	localparam int ACC_BITS    = SAMPLE_BITS + 4;
	localparam int TUNE_BITS   = 16;
	localparam int RES_BITS    = 16;
	localparam int COEF_FRAC   = 16;
	localparam int COEF_BITS   = COEF_FRAC + 1;
	localparam int MODE_BITS   = 2;
	localparam int DATA_BITS   = 32;
	localparam int ADDR_BITS   = 3;
	localparam int PROD_BITS   = ACC_BITS + COEF_BITS + 1;

	// Coefficient constants in Q0.16 / Q1.16.
	localparam logic [TUNE_BITS-1:0] TUNE_MAX   = 16'd64880;
	localparam logic [RES_BITS-1:0]  DAMP_SCALE = 16'd64880;
	localparam logic [COEF_BITS-1:0] DAMP_ONE   = 17'd65536;
	localparam logic [COEF_BITS-1:0] DAMP_FLOOR = 17'd655;

	// Limits of the stored state and of the output samples.
	localparam logic signed [ACC_BITS-1:0] SAMPLE_MAX =
		ACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [ACC_BITS-1:0] SAMPLE_MIN = -SAMPLE_MAX - ACC_BITS'(1);
	localparam logic signed [ACC_BITS-1:0] LIM4_RAW   = ACC_BITS'(64'sd4 <<< FRAC_BITS);
	localparam logic signed [ACC_BITS-1:0] STATE_LIM  =
		(LIM4_RAW > SAMPLE_MAX) ? SAMPLE_MAX : LIM4_RAW;
	localparam logic signed [ACC_BITS-1:0] STATE_NEG  = -STATE_LIM;

	// Register map.
	typedef enum logic [0:0] {
		REG_RESONANCE = 1'b0,
		REG_MODE      = 1'b1
	} reg_idx_t;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_LOW   = 2'd0,
		MODE_HIGH  = 2'd1,
		MODE_BAND  = 2'd2,
		MODE_NOTCH = 2'd3
	} mode_t;

	// Sequencer types.
	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_BF_IN,
		MUL_BQ,
		MUL_HF
	} mul_sel_t;

	typedef enum logic {
		JMP_NEXT,
		JMP_EMIT_END
	} jump_t;

	typedef logic [1:0] step_t;
	localparam step_t STEP_FIRST = 2'd0;

	typedef struct packed {
		mul_sel_t mul_sel;
		logic     ld_l1;
		logic     ld_h;
		jump_t    jump;
	} ctrl_word_t;

	// Microprogram for one sample. The first step runs in the cycle the request is taken.
	function automatic ctrl_word_t ucode(input step_t step);
		ctrl_word_t cw;
		case (step)
			2'd0:    cw = '{mul_sel: MUL_BF_IN, ld_l1: 1'b0, ld_h: 1'b0, jump: JMP_NEXT};
			2'd1:    cw = '{mul_sel: MUL_BQ,    ld_l1: 1'b1, ld_h: 1'b0, jump: JMP_NEXT};
			2'd2:    cw = '{mul_sel: MUL_HF,    ld_l1: 1'b0, ld_h: 1'b1, jump: JMP_NEXT};
			default: cw = '{mul_sel: MUL_NONE,  ld_l1: 1'b0, ld_h: 1'b0, jump: JMP_EMIT_END};
		endcase
		return cw;
	endfunction

	// Damping q = 1 - 0.99 * resonance, floored at 0.01, unsigned Q1.16.
	function automatic logic [COEF_BITS-1:0] damp_coef(input logic [RES_BITS-1:0] res);
		logic [2*RES_BITS-1:0] prod;
		logic [COEF_BITS-1:0]  q;
		prod = DAMP_SCALE * res;
		q = DAMP_ONE - COEF_BITS'(prod[2*RES_BITS-1:RES_BITS]);
		if (q < DAMP_FLOOR) begin
			q = DAMP_FLOOR;
		end
		return q;
	endfunction

	// Symmetric clamp of an integrator value to the state limit.
	function automatic logic signed [SAMPLE_BITS-1:0] clamp_state(
		input logic signed [ACC_BITS-1:0] v);
		logic signed [ACC_BITS-1:0] r;
		r = v;
		if (v > STATE_LIM) begin
			r = STATE_LIM;
		end else if (v < STATE_NEG) begin
			r = STATE_NEG;
		end
		return r[SAMPLE_BITS-1:0];
	endfunction

	// Saturation to the signed sample range.
	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [ACC_BITS-1:0] v);
		logic signed [ACC_BITS-1:0] r;
		r = v;
		if (v > SAMPLE_MAX) begin
			r = SAMPLE_MAX;
		end else if (v < SAMPLE_MIN) begin
			r = SAMPLE_MIN;
		end
		return r[SAMPLE_BITS-1:0];
	endfunction

endpackage

// ===== design/state_variable_filter_unit.sv =====
`timescale 1ns / 1ps
// A new request is not taken until the result of the last one has been emitted:
// the input stalls while a sample is worked on, and longer while the output stalls.
// The stall is set by three dependent multiplications sharing one multiplier.
// Reset (arst_n low, asynchronous) clears both channels' lowpass and bandpass state,
// sets resonance and response mode to zero and empties the output register.
module state_variable_filter_unit
	import svf_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	// Sample request channel.
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          channel,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic [TUNE_BITS-1:0]          tune,
	// Result channel.
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic                          out_channel,
	// Configuration port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_BITS-1:0]          paddr,
	input  logic [DATA_BITS-1:0]          pwdata,
	output logic [DATA_BITS-1:0]          prdata,
	output logic                          pready
);

	// Configuration registers.
	logic [RES_BITS-1:0]  resonance_q;
	mode_t                mode_q;
	logic [COEF_BITS-1:0] damp_q;
	reg_idx_t             reg_idx;
	logic                 cfg_we;

	// Per-channel integrator state.
	logic signed [SAMPLE_BITS-1:0] low_q  [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] band_q [CHANNELS];

	// Sequencer.
	seq_state_t state_q, state_d;
	step_t      step_q, step_d;
	ctrl_word_t cw;
	logic       accept_in;
	logic       exec_en;
	logic       emit;
	logic       out_free;

	// Operand registers of the sample being worked on.
	logic signed [SAMPLE_BITS-1:0] x_q, l_q, b_q;
	logic [COEF_BITS-1:0]          f_q;
	logic                          ch_q;
	logic [IDX_BITS-1:0]           idx_q;
	logic signed [ACC_BITS-1:0]    p_q, l1_q, h_q;

	// Datapath signals.
	logic [IDX_BITS-1:0]           in_idx;
	logic [COEF_BITS-1:0]          f_in;
	logic signed [ACC_BITS-1:0]    mul_a;
	logic [COEF_BITS-1:0]          mul_c;
	logic signed [PROD_BITS-1:0]   prod;
	logic signed [ACC_BITS-1:0]    h_comb, b1, n_sum;
	logic signed [SAMPLE_BITS-1:0] l1_clamped, b1_clamped, y;

	// Output register.
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic                          out_channel_q;

	// Configuration write decode and read mux.
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_BITS-1]);
	assign cfg_we  = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_idx)
			REG_RESONANCE: prdata = DATA_BITS'(resonance_q);
			REG_MODE:      prdata = DATA_BITS'(mode_q);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resonance_q <= '0;
			mode_q      <= MODE_LOW;
			damp_q      <= DAMP_ONE;
		end else if (cfg_we) begin
			case (reg_idx)
				REG_RESONANCE: begin
					resonance_q <= pwdata[RES_BITS-1:0];
					damp_q      <= damp_coef(pwdata[RES_BITS-1:0]);
				end
				REG_MODE: begin
					mode_q <= mode_t'(pwdata[MODE_BITS-1:0]);
				end
				default: begin
					mode_q <= mode_q;
				end
			endcase
		end
	end

	// Handshake status.
	assign in_stall  = (state_q != SEQ_IDLE);
	assign accept_in = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// Sequencer: fetch the control word, advance the step counter, hold on a full output.
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		exec_en = 1'b0;
		emit    = 1'b0;
		cw      = ucode(step_q);
		case (state_q)
			SEQ_IDLE: begin
				cw = ucode(STEP_FIRST);
				if (accept_in) begin
					exec_en = 1'b1;
					state_d = SEQ_RUN;
					step_d  = STEP_FIRST + step_t'(1);
				end
			end
			SEQ_RUN: begin
				case (cw.jump)
					JMP_NEXT: begin
						exec_en = 1'b1;
						step_d  = step_q + step_t'(1);
					end
					JMP_EMIT_END: begin
						if (out_free) begin
							exec_en = 1'b1;
							emit    = 1'b1;
							state_d = SEQ_IDLE;
							step_d  = STEP_FIRST;
						end
					end
					default: begin
						state_d = SEQ_IDLE;
						step_d  = STEP_FIRST;
					end
				endcase
			end
			default: begin
				state_d = SEQ_IDLE;
				step_d  = STEP_FIRST;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			step_q  <= STEP_FIRST;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	// Incoming channel index and clamped tuning coefficient.
	assign in_idx = IDX_BITS'(32'(channel) % CHANNELS);
	assign f_in   = COEF_BITS'((tune > TUNE_MAX) ? TUNE_MAX : tune);

	// Shared multiplier operand select.
	always_comb begin
		case (cw.mul_sel)
			MUL_BF_IN: begin
				mul_a = ACC_BITS'(band_q[in_idx]);
				mul_c = f_in;
			end
			MUL_BQ: begin
				mul_a = ACC_BITS'(b_q);
				mul_c = damp_q;
			end
			MUL_HF: begin
				mul_a = h_comb;
				mul_c = f_q;
			end
			default: begin
				mul_a = '0;
				mul_c = '0;
			end
		endcase
	end

	// Product rounded toward minus infinity by dropping the coefficient fraction.
	assign prod = mul_a * $signed({1'b0, mul_c});

	// Adders around the multiplier.
	assign h_comb = ACC_BITS'(x_q) - l1_q - p_q;
	assign b1     = ACC_BITS'(b_q) + p_q;
	assign n_sum  = h_q + l1_q;

	assign l1_clamped = clamp_state(l1_q);
	assign b1_clamped = clamp_state(b1);

	// Response select.
	always_comb begin
		case (mode_q)
			MODE_LOW:   y = l1_clamped;
			MODE_HIGH:  y = sat_sample(h_q);
			MODE_BAND:  y = b1_clamped;
			MODE_NOTCH: y = sat_sample(n_sum);
			default:    y = l1_clamped;
		endcase
	end

	// Operand and intermediate registers.
	always_ff @(posedge clk) begin
		if (accept_in) begin
			x_q   <= sample_in;
			f_q   <= f_in;
			ch_q  <= channel;
			idx_q <= in_idx;
			l_q   <= low_q[in_idx];
			b_q   <= band_q[in_idx];
		end
		if (exec_en && (cw.mul_sel != MUL_NONE)) begin
			p_q <= prod[COEF_FRAC +: ACC_BITS];
		end
		if (exec_en && cw.ld_l1) begin
			l1_q <= ACC_BITS'(l_q) + p_q;
		end
		if (exec_en && cw.ld_h) begin
			h_q <= h_comb;
		end
	end

	// Integrator state write-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				low_q[i]  <= '0;
				band_q[i] <= '0;
			end
		end else if (emit) begin
			low_q[idx_q]  <= l1_clamped;
			band_q[idx_q] <= b1_clamped;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			sample_out_q  <= y;
			out_channel_q <= ch_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign sample_out  = sample_out_q;
	assign out_channel = out_channel_q;

endmodule

// ===== design/svf_checker.sv =====
`timescale 1ns / 1ps
module svf_checker
	import svf_pkg::*;
(
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [SAMPLE_BITS-1:0] sample_out,
	input logic                          out_channel
);

	// A taken request keeps the input stalled for the three following sequencer steps.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall ##1 in_stall ##1 in_stall)
		else $error("input accepted again before the sample finished");

	// The input only stalls after a request was taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid))
		else $error("input stalled without a request");

	// A new result appears together with the input becoming free again.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result shown while the sequencer is still busy");

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			(out_valid && $stable(sample_out) && $stable(out_channel)))
		else $error("stalled result changed or dropped");

endmodule

bind state_variable_filter_unit svf_checker u_svf_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import svf_pkg::*;

	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 24'sh800000;
	localparam int PHASES     = 10;
	localparam int PHASE_LEN  = 85;
	localparam int PLAN_ROWS  = 22;
	localparam int HOLD_AFTER = 300;
	localparam int HOLD_LEN   = 60;

	typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	typedef struct {
		row_kind_t                     kind;
		reg_idx_t                      cfg_reg;
		int                            cfg_val;
		logic                          ch;
		logic signed [SAMPLE_BITS-1:0] x;
		logic [TUNE_BITS-1:0]          t;
		bit                            known;
		logic signed [SAMPLE_BITS-1:0] known_val;
	} svf_row_t;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          chan;
	} svf_result_t;

	// Clock, reset and every input of the block start at known values.
	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic                          channel = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample_in = '0;
	logic [TUNE_BITS-1:0]          tune = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          out_channel;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [ADDR_BITS-1:0]          paddr = '0;
	logic [DATA_BITS-1:0]          pwdata = '0;
	logic [DATA_BITS-1:0]          prdata;
	logic                          pready;

	// Filter state and register copies kept by the predictor.
	longint              lp_state [CHANNELS];
	longint              bp_state [CHANNELS];
	logic [RES_BITS-1:0] res_copy;
	mode_t               mode_copy;

	svf_result_t pending_results [$];
	int          err_count = 0;
	int          accepted_count = 0;
	logic        tx_idle = 1'b1;
	logic        rx_idle = 1'b1;
	logic        hold_out = 1'b0;

	// Directed plan: extremes, tune clamp, every response mode, resonance extremes.
	svf_row_t plan [PLAN_ROWS] = '{
		'{ROW_SAMPLE, REG_RESONANCE, 0, 1'b0, S_MAX, 16'd65535, 1'b1, 24'sd0},
		'{ROW_SAMPLE, REG_RESONANCE, 0, 1'b1, S_MIN, 16'd0, 1'b1, 24'sd0},
		'{ROW_SAMPLE, REG_RESONANCE, 0, 1'b1, S_MIN, 16'd64880, 1'b1, 24'sd0},
		'{ROW_SAMPLE, REG_RESONANCE, 0, 1'b0, S_MAX, 16'd64881, 1'b0, 24'sd0},
		'{ROW_SAMPLE, REG_RESONANCE, 0, 1'b0, S_MAX, 16'd65535, 1'b0, 24'sd0},
		'{ROW_SAMPLE, REG_RESONANCE, 0, 1'b0, S_MAX, 16'd65535, 1'b0, 24'sd0},
		'{ROW_SAMPLE, REG_RESONANCE, 0, 1'b1, S_MIN, 16'd65535, 1'b0, 24'sd0},
		'{ROW_SAMPLE, REG_RESONANCE, 0, 1'b1, S_MIN, 16'd65535, 1'b0, 24'sd0},
		'{ROW_WRITE,  REG_MODE, int'(MODE_HIGH), 1'b0, 24'sd0, 16'd0, 1'b0, 24'sd0},
		'{ROW_SAMPLE, REG_RESONANCE, 0, 1'b1, S_MAX, 16'd65535, 1'b0, 24'sd0},
		'{ROW_SAMPLE, REG_RESONANCE, 0, 1'b0, S_MIN, 16'd65535, 1'b0, 24'sd0},
		'{ROW_WRITE,  REG_RESONANCE, 65535, 1'b0, 24'sd0, 16'd0, 1'b0, 24'sd0},
		'{ROW_WRITE,  REG_MODE, int'(MODE_BAND), 1'b0, 24'sd0, 16'd0, 1'b0, 24'sd0},
		'{ROW_SAMPLE, REG_RESONANCE, 0, 1'b0, 24'sd0, 16'd0, 1'b0, 24'sd0},
		'{ROW_SAMPLE, REG_RESONANCE, 0, 1'b1, 24'sd1, 16'd64880, 1'b0, 24'sd0},
		'{ROW_WRITE,  REG_MODE, int'(MODE_NOTCH), 1'b0, 24'sd0, 16'd0, 1'b0, 24'sd0},
		'{ROW_SAMPLE, REG_RESONANCE, 0, 1'b0, S_MAX, 16'd65535, 1'b0, 24'sd0},
		'{ROW_SAMPLE, REG_RESONANCE, 0, 1'b1, S_MIN, 16'd65535, 1'b0, 24'sd0},
		'{ROW_SAMPLE, REG_RESONANCE, 0, 1'b0, -24'sd1, 16'd1, 1'b0, 24'sd0},
		'{ROW_WRITE,  REG_RESONANCE, 0, 1'b0, 24'sd0, 16'd0, 1'b0, 24'sd0},
		'{ROW_WRITE,  REG_MODE, int'(MODE_LOW), 1'b0, 24'sd0, 16'd0, 1'b0, 24'sd0},
		'{ROW_SAMPLE, REG_RESONANCE, 0, 1'b1, S_MAX, 16'd32768, 1'b0, 24'sd0}
	};

	state_variable_filter_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.channel    (channel),
		.sample_in  (sample_in),
		.tune       (tune),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.out_channel(out_channel),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Product of a sample and a Q0.16 or Q1.16 coefficient, rounded toward minus infinity.
	function automatic longint q16_product(input longint a, input longint c);
		return (a * c) >>> COEF_FRAC;
	endfunction

	function automatic longint limit_to(input longint v, input longint lo, input longint hi);
		if (v > hi) begin
			return hi;
		end
		if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	// One filter update for a request; advances the predicted channel state.
	function automatic svf_result_t filter_step(input logic ch,
		input logic signed [SAMPLE_BITS-1:0] x, input logic [TUNE_BITS-1:0] t);
		longint f, q, lp1, hp, bp1, nt, top, lim, y;
		int idx;
		svf_result_t r;
		idx = int'(ch) % CHANNELS;
		f = (t > TUNE_MAX) ? longint'(TUNE_MAX) : longint'(t);
		q = longint'(DAMP_ONE) - ((longint'(DAMP_SCALE) * longint'(res_copy)) >>> RES_BITS);
		if (q < longint'(DAMP_FLOOR)) begin
			q = longint'(DAMP_FLOOR);
		end
		top = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
		lim = longint'(4) <<< FRAC_BITS;
		if (lim > top) begin
			lim = top;
		end
		lp1 = lp_state[idx] + q16_product(bp_state[idx], f);
		hp = longint'(x) - lp1 - q16_product(bp_state[idx], q);
		bp1 = bp_state[idx] + q16_product(hp, f);
		nt = hp + lp1;
		lp1 = limit_to(lp1, -lim, lim);
		bp1 = limit_to(bp1, -lim, lim);
		lp_state[idx] = lp1;
		bp_state[idx] = bp1;
		case (mode_copy)
			MODE_HIGH:  y = limit_to(hp, -top - 1, top);
			MODE_BAND:  y = bp1;
			MODE_NOTCH: y = limit_to(nt, -top - 1, top);
			default:    y = lp1;
		endcase
		r.sample = y[SAMPLE_BITS-1:0];
		r.chan = ch;
		return r;
	endfunction

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		err_count++;
	endtask

	// Offers one request, after a random gap while tx_idle is set; returns at the falling edge after acceptance.
	task automatic push_sample(input logic ch, input logic signed [SAMPLE_BITS-1:0] x,
		input logic [TUNE_BITS-1:0] t, input bit known,
		input logic signed [SAMPLE_BITS-1:0] known_val);
		int gap;
		svf_result_t r;
		gap = tx_idle ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		channel <= ch;
		sample_in <= x;
		tune <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		r = filter_step(ch, x, t);
		if (known) begin
			r.sample = known_val;
		end
		pending_results.push_back(r);
		accepted_count++;
		@(negedge clk);
	endtask

	// Stops offering requests and lets every outstanding result come back.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Register write in a setup and an access cycle; only called while the block is idle.
	task automatic program_register(input reg_idx_t idx, input int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_BITS'({idx, 2'b00});
		pwdata <= DATA_BITS'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_RESONANCE: res_copy = value[RES_BITS-1:0];
			default:       mode_copy = mode_t'(value[MODE_BITS-1:0]);
		endcase
	endtask

	// Stimulus: directed plan, then random phases under changing settings.
	initial begin : stimulus
		int p, k, sel;
		logic signed [SAMPLE_BITS-1:0] x;
		logic [TUNE_BITS-1:0] t;
		for (k = 0; k < CHANNELS; k++) begin
			lp_state[k] = 0;
			bp_state[k] = 0;
		end
		res_copy = '0;
		mode_copy = MODE_LOW;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				wait_for_drain();
				program_register(plan[i].cfg_reg, plan[i].cfg_val);
			end else begin
				push_sample(plan[i].ch, plan[i].x, plan[i].t, plan[i].known,
					plan[i].known_val);
			end
		end

		for (p = 0; p < PHASES; p++) begin
			wait_for_drain();
			case (p)
				1:       program_register(REG_RESONANCE, 65535);
				2:       program_register(REG_RESONANCE, 0);
				default: program_register(REG_RESONANCE, int'($urandom_range(0, 65535)));
			endcase
			program_register(REG_MODE, (p < 8) ? (p % 4) : int'($urandom_range(0, 3)));
			tx_idle <= (p % 5 != 4);
			rx_idle <= (p % 5 != 3);
			for (k = 0; k < PHASE_LEN; k++) begin
				sel = $urandom_range(0, 9);
				case (sel)
					0:       x = S_MAX;
					1:       x = S_MIN;
					2, 3, 4: x = SAMPLE_BITS'($signed($urandom_range(0, 8191)) - 4096);
					default: x = SAMPLE_BITS'($urandom());
				endcase
				sel = $urandom_range(0, 9);
				case (sel)
					0:       t = '0;
					1:       t = '1;
					2:       t = TUNE_BITS'(int'(TUNE_MAX) - 2 + int'($urandom_range(0, 4)));
					3, 4, 5: t = TUNE_BITS'($urandom_range(0, 4095));
					default: t = TUNE_BITS'($urandom());
				endcase
				push_sample(1'($urandom()), x, t, 1'b0, '0);
			end
		end

		wait_for_drain();
		repeat (8) @(negedge clk);
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Result side: random stall before each result while rx_idle is set, long hold-off on request.
	initial begin : result_side
		int w;
		svf_result_t e;
		wait (arst_n);
		@(negedge clk);
		forever begin
			w = rx_idle ? $urandom_range(0, 4) : 0;
			if (w > 0 || hold_out) begin
				out_stall <= 1'b1;
				repeat (w) @(negedge clk);
				while (hold_out) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (pending_results.size() == 0) begin
				report_error($sformatf("result %0d on channel %0d with none expected",
					sample_out, out_channel));
			end else begin
				e = pending_results.pop_front();
				if (sample_out !== e.sample) begin
					report_error($sformatf("sample_out %0d, expected %0d",
						sample_out, e.sample));
				end
				if (out_channel !== e.chan) begin
					report_error($sformatf("out_channel %0d, expected %0d",
						out_channel, e.chan));
				end
			end
			@(negedge clk);
		end
	end

	// Back-pressure: hold the output long enough that the block stalls its input.
	initial begin : hold_off
		wait (accepted_count >= HOLD_AFTER);
		@(negedge clk);
		hold_out <= 1'b1;
		repeat (HOLD_LEN) @(negedge clk);
		hold_out <= 1'b0;
	end

	initial begin : watchdog
		#400000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/svf_pkg.sv
design/state_variable_filter_unit.sv
design/svf_checker.sv
tb/testbench.sv
